### src/blm_pkg.sv
// Shared types, constants and the BCD helper for the battery level monitor.
// No dependencies; imported by blm_div and battery_level_monitor.
`timescale 1ns / 1ps

package blm_pkg;

    // Default ADC resolution
    localparam int ADC_BITS_DEF = 12;

    // Shared divider geometry: 32-bit dividend, 17-bit divisor
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 17;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Register reset values
    localparam logic [19:0] INTERVAL_RST = 20'd1000;
    localparam logic [15:0] FULL_MV_SCALE_RST = 16'd6600;
    localparam logic [11:0] ADC_FS_RST   = 12'd4095;
    localparam logic [15:0] EMPTY_MV_RST = 16'd3000;
    localparam logic [15:0] FULL_MV_RST  = 16'd4200;
    localparam logic [6:0]  HYST_RST     = 7'd2;

    localparam logic [6:0] PCT_FULL = 7'd100;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVAL  = 3'd0,
        CFG_FS_MV     = 3'd1,
        CFG_ADC_FS    = 3'd2,
        CFG_EMPTY_MV  = 3'd3,
        CFG_FULL_MV   = 3'd4,
        CFG_HYST      = 3'd5
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATE,
        ST_MUL,
        ST_MV_START,
        ST_DIV_MV,
        ST_PCT,
        ST_DIV_PCT,
        ST_FINISH
    } state_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // BCD word: ones at 15:12, tens at 11:8, hundreds at 7:4, low nibble zero
    function automatic logic [15:0] bcd_word(input logic [6:0] p);
        logic        h;
        logic [6:0]  r;
        logic [14:0] m;
        logic [3:0]  t;
        logic [6:0]  o;
        h = (p >= PCT_FULL);
        r = h ? (p - PCT_FULL) : p;
        // r/10 by reciprocal, exact for every 7-bit r
        m = 15'(r) * 15'd205;
        t = m[14:11];
        o = r - 7'({t, 3'b000}) - 7'({t, 1'b0});
        return {o[3:0], t, 3'b000, h, 4'b0000};
    endfunction

endpackage

### src/blm_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on blm_pkg for the status struct.
`timescale 1ns / 1ps

module blm_div #(
    parameter int NUM_W = blm_pkg::DIV_NUM_W,
    parameter int DEN_W = blm_pkg::DIV_DEN_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [NUM_W-1:0] quotient,
    output blm_pkg::div_stat_t stat
);
    import blm_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;
    logic             fits;

    // One compare-subtract step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        trial   = shifted - {1'b0, den_reg};
        fits    = (shifted >= {1'b0, den_reg});
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(NUM_W - 1);
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = run_reg;
    assign stat.done = done_reg;

endmodule

### src/battery_level_monitor.sv
// Battery level monitor: interval gate, running average, mV scaling,
// percentage with hysteresis and BCD display. Depends on blm_pkg, blm_div.
// A request ends early when the gate or the read fails, or after the mV divide when
// the mV value clamps; otherwise it takes a second divide. Each divider pass has 32 steps.
// Requests are taken one at a time; the next is taken once the sequencer is back in idle.
// Reset: asynchronous active-low; configuration registers return to defaults, state to zero.
`timescale 1ns / 1ps

module battery_level_monitor #(
    parameter int ADC_BITS = blm_pkg::ADC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [blm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [blm_pkg::CFG_DATA_W-1:0] cfg_data,
    // sample requests
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [31:0]                    now_ms,
    input  logic [ADC_BITS-1:0]            adc_sample,
    input  logic                           read_ok,
    // results
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           sample_taken,
    output logic [6:0]                     level_pct,
    output logic [15:0]                    display_word
);
    import blm_pkg::*;

    localparam int PROD_W = ADC_BITS + 16;

    // configuration registers
    logic [19:0] interval_reg;
    logic [15:0] fs_mv_reg;
    logic [11:0] adc_fs_reg;
    logic [15:0] empty_reg;
    logic [15:0] full_reg;
    logic [6:0]  hyst_reg;

    // monitor state
    logic [31:0]         last_reg;
    logic [ADC_BITS-1:0] avg_reg;
    logic                seeded_reg;
    logic [6:0]          rep_reg;

    // latched request and working values
    logic [31:0]         now_reg;
    logic [ADC_BITS-1:0] smp_reg;
    logic                ok_reg;
    logic                taken_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [6:0]          np_reg;

    // result registers
    logic        out_valid_reg;
    logic        out_taken_reg;
    logic [6:0]  out_pct_reg;
    logic [15:0] out_disp_reg;

    state_t state_reg, state_next;

    // divider hookup
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quo;
    div_stat_t            div_stat;

    blm_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // gate and average update
    logic [31:0]         elapsed;
    logic                gate_pass;
    logic [ADC_BITS+1:0] avg_sum;
    logic [ADC_BITS-1:0] avg_upd;

    always_comb
    begin
        elapsed   = now_reg - last_reg;
        gate_pass = (elapsed >= {12'd0, interval_reg});
        avg_sum   = {2'b00, avg_reg} + {1'b0, avg_reg, 1'b0} + {2'b00, smp_reg};
        avg_upd   = seeded_reg ? avg_sum[ADC_BITS+1:2] : smp_reg;
    end

    // percentage mapping, using the mV quotient
    logic [31:0] mv;
    logic        mv_low;
    logic        mv_high;
    logic [15:0] span;
    logic [15:0] mv_ofs;
    logic [23:0] pct_num;

    always_comb
    begin
        mv      = div_quo;
        mv_low  = (mv <= {16'd0, empty_reg});
        mv_high = (mv >= {16'd0, full_reg});
        span    = full_reg - empty_reg;
        mv_ofs  = mv[15:0] - empty_reg;
        // 200*x + span
        pct_num = {1'b0, mv_ofs, 7'b0} + {2'b0, mv_ofs, 6'b0}
                + {5'b0, mv_ofs, 3'b0} + {8'd0, span};
    end

    // hysteresis on the new percentage
    logic [6:0] pct_diff;

    always_comb
    begin
        pct_diff = (np_reg > rep_reg) ? (np_reg - rep_reg) : (rep_reg - np_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_GATE;
                end
            end
            ST_GATE:
            begin
                state_next = (gate_pass && ok_reg) ? ST_MUL : ST_FINISH;
            end
            ST_MUL:
            begin
                state_next = ST_MV_START;
            end
            ST_MV_START:
            begin
                state_next = ST_DIV_MV;
            end
            ST_DIV_MV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_PCT;
                end
            end
            ST_PCT:
            begin
                state_next = (mv_low || mv_high) ? ST_FINISH : ST_DIV_PCT;
            end
            ST_DIV_PCT:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        div_num   = DIV_NUM_W'(prod_reg);
        div_den   = (adc_fs_reg == 12'd0) ? DIV_DEN_W'(1) : DIV_DEN_W'(adc_fs_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_MV_START:
            begin
                div_start = 1'b1;
            end
            ST_PCT:
            begin
                div_start = !(mv_low || mv_high);
                div_num   = DIV_NUM_W'(pct_num);
                div_den   = {span, 1'b0};
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RST;
            fs_mv_reg    <= FULL_MV_SCALE_RST;
            adc_fs_reg   <= ADC_FS_RST;
            empty_reg    <= EMPTY_MV_RST;
            full_reg     <= FULL_MV_RST;
            hyst_reg     <= HYST_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_INTERVAL: interval_reg <= cfg_data;
                CFG_FS_MV:    fs_mv_reg    <= cfg_data[15:0];
                CFG_ADC_FS:   adc_fs_reg   <= cfg_data[11:0];
                CFG_EMPTY_MV: empty_reg    <= cfg_data[15:0];
                CFG_FULL_MV:  full_reg     <= cfg_data[15:0];
                CFG_HYST:     hyst_reg     <= cfg_data[6:0];
                default:      hyst_reg     <= hyst_reg;
            endcase
        end
    end

    // control and monitor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= '0;
            avg_reg       <= '0;
            seeded_reg    <= 1'b0;
            rep_reg       <= '0;
            taken_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // result slot: filled on finish, emptied on handoff
            if (state_reg == ST_FINISH && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    taken_reg <= 1'b0;
                end
                ST_GATE:
                begin
                    if (gate_pass)
                    begin
                        last_reg <= now_reg;
                        if (ok_reg)
                        begin
                            avg_reg    <= avg_upd;
                            seeded_reg <= 1'b1;
                            taken_reg  <= 1'b1;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (taken_reg && (pct_diff > hyst_reg))
                    begin
                        rep_reg <= np_reg;
                    end
                end
                default:
                begin
                    taken_reg <= taken_reg;
                end
            endcase
        end
    end

    // request latch, datapath and result payload
    logic [6:0] rep_new;

    always_comb
    begin
        rep_new = (taken_reg && (pct_diff > hyst_reg)) ? np_reg : rep_reg;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            now_reg <= now_ms;
            smp_reg <= adc_sample;
            ok_reg  <= read_ok;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(avg_reg) * PROD_W'(fs_mv_reg);
        end
        if (state_reg == ST_PCT)
        begin
            np_reg <= mv_low ? 7'd0 : PCT_FULL;
        end
        if (state_reg == ST_DIV_PCT && div_stat.done)
        begin
            np_reg <= div_quo[6:0];
        end
        if (state_reg == ST_FINISH && (!out_valid_reg || out_ready))
        begin
            out_taken_reg <= taken_reg;
            out_pct_reg   <= rep_new;
            out_disp_reg  <= bcd_word(rep_new);
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_taken = out_taken_reg;
    assign level_pct    = out_pct_reg;
    assign display_word = out_disp_reg;

endmodule
